/* sv/sdmg_pkg.sv */
package sdmg_pkg;

    // Field widths
    localparam int DIV_W   = 32;
    localparam int MAG_W   = 34;
    localparam int SHIFT_W = 5;
    localparam int PREC_W  = 6;

    // Stream widths (output fields padded to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // Fixed points of the algorithm
    localparam logic [DIV_W-1:0]  TWO31      = 32'h8000_0000;
    localparam logic [PREC_W-1:0] START_PREC = 6'd31;
    localparam logic [PREC_W-1:0] PREC_CAP   = 6'd63;
    localparam logic [PREC_W-1:0] WORD_PREC  = 6'd32;
    localparam logic [4:0]        LAST_STEP  = 5'd31;

    // Sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SETUP  = 10'b00_0000_0010,
        ST_DIV_T  = 10'b00_0000_0100,
        ST_ANC    = 10'b00_0000_1000,
        ST_DIV1   = 10'b00_0001_0000,
        ST_DIV2   = 10'b00_0010_0000,
        ST_STEP1  = 10'b00_0100_0000,
        ST_STEP2  = 10'b00_1000_0000,
        ST_TEST   = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } state_t;

    // Kind of divisor, decided at setup
    typedef enum logic [1:0] {
        SPEC_NORMAL    = 2'd0,
        SPEC_ZERO      = 2'd1,
        SPEC_ONE       = 2'd2,
        SPEC_MINUS_ONE = 2'd3
    } spec_t;

endpackage

/* sv/sdmg_step.sv */
// One restoring division step: shift a bit into the remainder, then
// compare and subtract the divisor.
module sdmg_step
    import sdmg_pkg::*;
(
    input  logic [DIV_W-1:0] rem_in,
    input  logic [DIV_W-1:0] den,
    input  logic             bit_in,
    output logic [DIV_W-1:0] rem_out,
    output logic             qbit
);

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] diff;

    // Shift and trial subtract; the remainder stays below den, so 32 bits hold it
    always_comb
    begin
        shifted = {rem_in, bit_in};
        diff    = shifted - {1'b0, den};
        qbit    = (shifted >= {1'b0, den});
        rem_out = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end

endmodule

/* sv/signed_div_magic_constant_gen.sv */
// Channel  Direction  Width  Contents
// s_*      in         32     tdata[31:0] divisor
// m_*      out        48     tdata[33:0] magic_multiplier, [38:34] post_shift,
//                            [39] add_dividend, [40] divide_error, rest zero
//
// A general divisor needs 1 to 32 doubling iterations; divisors 0, 1 and -1
// go from setup straight to the finish state. All division steps run through
// one compare-subtract step unit: three 32-step restoring divisions, then
// two unit steps and one stop test per doubling iteration. s_tready is high
// only while the sequencer is idle, and a result that waits on m_tready holds
// the sequencer in its last state until the output register frees. rst_n
// clears the sequencer and m_tvalid.
module signed_div_magic_constant_gen
    import sdmg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] divisor
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [33:0] magic_multiplier, [38:34] post_shift,
                                           // [39] add_dividend, [40] divide_error
);

    state_t               state_reg, state_next;
    spec_t                spec_reg, spec_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DIV_W-1:0]     d_reg, d_next;
    logic [DIV_W-1:0]     ad_reg, ad_next;
    logic [DIV_W-1:0]     anc_reg, anc_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     r1_reg, r1_next;
    logic [DIV_W-1:0]     r2_reg, r2_next;
    logic [MAG_W-1:0]     q1_reg, q1_next;
    logic [MAG_W-1:0]     q2_reg, q2_next;
    logic                 neg_reg, neg_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [PREC_W-1:0]    p_reg, p_next;
    logic [MAG_W-1:0]     omag_reg, omag_next;
    logic [SHIFT_W-1:0]   oshift_reg, oshift_next;
    logic                 oadd_reg, oadd_next;
    logic                 oerr_reg, oerr_next;

    logic [DIV_W-1:0]     u_rem_in, u_den, u_rem_out;
    logic                 u_bit_in, u_qbit;
    logic                 pair1_sel;

    logic [DIV_W-1:0]     t_val, anc_raw;
    logic [MAG_W-1:0]     delta, mag, magic;
    logic [PREC_W-1:0]    p_off;
    logic                 stop;
    logic                 out_free;

    // Shared compare-subtract unit
    sdmg_step u_step (
        .rem_in  (u_rem_in),
        .den     (u_den),
        .bit_in  (u_bit_in),
        .rem_out (u_rem_out),
        .qbit    (u_qbit)
    );

    // Route the unit to the quotient pair the current state works on
    always_comb
    begin
        pair1_sel = (state_reg == ST_DIV_T) || (state_reg == ST_DIV1)
                 || (state_reg == ST_STEP1);
        u_rem_in  = pair1_sel ? r1_reg : r2_reg;
        u_den     = ((state_reg == ST_DIV1) || (state_reg == ST_STEP1)) ? anc_reg : ad_reg;
        u_bit_in  = ((state_reg == ST_DIV_T) || (state_reg == ST_DIV1)
                  || (state_reg == ST_DIV2)) ? dvd_reg[DIV_W-1] : 1'b0;
    end

    // Derived values for anc, the stop test and the result
    always_comb
    begin
        t_val   = TWO31 | {{(DIV_W-1){1'b0}}, neg_reg};
        anc_raw = t_val - 32'd1 - r1_reg;
        delta   = {2'b00, ad_reg} - {2'b00, r2_reg};
        stop    = (q1_reg > delta) || ((q1_reg == delta) && (r1_reg != '0));
        mag     = q2_reg + 34'd1;
        magic   = neg_reg ? (34'd0 - mag) : mag;
        p_off   = p_reg - WORD_PREC;
        out_free = !m_tvalid_reg || m_tready;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        spec_next     = spec_reg;
        m_tvalid_next = m_tvalid_reg;
        d_next        = d_reg;
        ad_next       = ad_reg;
        anc_next      = anc_reg;
        dvd_next      = dvd_reg;
        r1_next       = r1_reg;
        r2_next       = r2_reg;
        q1_next       = q1_reg;
        q2_next       = q2_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        p_next        = p_reg;
        omag_next     = omag_reg;
        oshift_next   = oshift_reg;
        oadd_next     = oadd_reg;
        oerr_next     = oerr_reg;

        // Drop the result once the transaction completes
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    d_next     = s_tdata[DIV_W-1:0];
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                neg_next = d_reg[DIV_W-1];
                ad_next  = d_reg[DIV_W-1] ? (32'd0 - d_reg) : d_reg;
                dvd_next = TWO31 | {{(DIV_W-1){1'b0}}, d_reg[DIV_W-1]};
                r1_next  = '0;
                q1_next  = '0;
                cnt_next = '0;
                priority if (d_reg == '0)
                begin
                    spec_next  = SPEC_ZERO;
                    state_next = ST_FINISH;
                end
                else if (d_reg == 32'd1)
                begin
                    spec_next  = SPEC_ONE;
                    state_next = ST_FINISH;
                end
                else if (d_reg == '1)
                begin
                    spec_next  = SPEC_MINUS_ONE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    spec_next  = SPEC_NORMAL;
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T, ST_DIV1:
            begin
                // Pair one holds t % ad first, then 2^31 / anc
                r1_next  = u_rem_out;
                q1_next  = {q1_reg[MAG_W-2:0], u_qbit};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == ST_DIV_T) ? ST_ANC : ST_DIV2;
                    dvd_next   = TWO31;
                end
            end
            ST_ANC:
            begin
                anc_next   = (anc_raw == '0) ? 32'd1 : anc_raw;
                r1_next    = '0;
                q1_next    = '0;
                r2_next    = '0;
                q2_next    = '0;
                dvd_next   = TWO31;
                cnt_next   = '0;
                p_next     = START_PREC;
                state_next = ST_DIV1;
            end
            ST_DIV2:
            begin
                r2_next  = u_rem_out;
                q2_next  = {q2_reg[MAG_W-2:0], u_qbit};
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = ST_STEP1;
                end
            end
            ST_STEP1:
            begin
                // Double pair one and raise the precision
                r1_next    = u_rem_out;
                q1_next    = {q1_reg[MAG_W-2:0], u_qbit};
                p_next     = p_reg + 6'd1;
                state_next = ST_STEP2;
            end
            ST_STEP2:
            begin
                r2_next    = u_rem_out;
                q2_next    = {q2_reg[MAG_W-2:0], u_qbit};
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = (stop || (p_reg == PREC_CAP)) ? ST_FINISH : ST_STEP1;
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    omag_next     = '0;
                    oshift_next   = '0;
                    oadd_next     = 1'b0;
                    oerr_next     = 1'b0;
                    unique case (spec_reg)
                        SPEC_ZERO:      oerr_next = 1'b1;
                        SPEC_ONE:       omag_next = 34'd1;
                        SPEC_MINUS_ONE: omag_next = '1;
                        default:
                        begin
                            omag_next   = magic;
                            oshift_next = p_off[SHIFT_W-1:0];
                            oadd_next   = neg_reg;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        spec_reg   <= spec_next;
        d_reg      <= d_next;
        ad_reg     <= ad_next;
        anc_reg    <= anc_next;
        dvd_reg    <= dvd_next;
        r1_reg     <= r1_next;
        r2_reg     <= r2_next;
        q1_reg     <= q1_next;
        q2_reg     <= q2_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        p_reg      <= p_next;
        omag_reg   <= omag_next;
        oshift_reg <= oshift_next;
        oadd_reg   <= oadd_next;
        oerr_reg   <= oerr_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, oerr_reg, oadd_reg, oshift_reg, omag_reg};

    // An accepted transaction always starts the setup step
    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_SETUP))
        else $error("accepted divisor did not reach setup");

    // Both remainders stay below their divisors through the doubling loop
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> ((r1_reg < anc_reg) && (r2_reg < ad_reg)))
        else $error("remainder not below divisor");

    // The loop test only runs above the starting precision
    a_prec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TEST) |-> (p_reg > START_PREC))
        else $error("precision out of range in loop");

    // A divide error carries no other result bits
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[40]) |-> (m_tdata[39:0] == '0))
        else $error("error result with nonzero fields");

endmodule

/* test/magic_result_monitor.sv */
module magic_result_monitor
    import sdmg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] divisor
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,  // [33:0] magic_multiplier, [38:34] post_shift,
                                           // [39] add_dividend, [40] divide_error
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MAG_W-1:0]   magic;
        logic [SHIFT_W-1:0] shift;
        logic               add;
        logic               err;
    } magic_result_t;

    magic_result_t expected_magic_q[$];

    // Derive multiplier, shift and add flag for one divisor
    function automatic magic_result_t compute_magic(input logic [DIV_W-1:0] d);
        magic_result_t res;
        logic          neg;
        logic [31:0]   abs_d;
        logic [63:0]   ad, t, anc, q1, r1, q2, r2, delta, mag, magic;
        int            prec;
        bit            done;
        res = '0;
        neg = d[DIV_W-1];
        if (d == '0) begin
            res.err = 1'b1;
        end
        else if (d == 32'd1) begin
            res.magic = 34'd1;
        end
        else if (d == '1) begin
            // minus one keeps the add flag clear
            res.magic = '1;
        end
        else begin
            abs_d = neg ? (~d + 32'd1) : d;
            ad    = 64'(abs_d);
            t     = 64'(TWO31) + (neg ? 64'd1 : 64'd0);
            anc   = t - 64'd1 - (t % ad);
            if (anc == 64'd0)
                anc = 64'd1;
            q1 = 64'(TWO31) / anc;
            r1 = 64'(TWO31) - q1 * anc;
            q2 = 64'(TWO31) / ad;
            r2 = 64'(TWO31) - q2 * ad;
            prec = int'(START_PREC);
            done = 1'b0;
            // Double both quotient/remainder pairs until the stop test holds
            while (prec < int'(PREC_CAP) && !done) begin
                prec++;
                q1 = q1 << 1;
                r1 = r1 << 1;
                if (r1 >= anc) begin
                    q1 = q1 + 64'd1;
                    r1 = r1 - anc;
                end
                q2 = q2 << 1;
                r2 = r2 << 1;
                if (r2 >= ad) begin
                    q2 = q2 + 64'd1;
                    r2 = r2 - ad;
                end
                delta = ad - r2;
                if (q1 > delta || (q1 == delta && r1 != 64'd0))
                    done = 1'b1;
            end
            mag       = q2 + 64'd1;
            magic     = neg ? (64'd0 - mag) : mag;
            res.magic = magic[MAG_W-1:0];
            res.shift = SHIFT_W'(prec - int'(WORD_PREC));
            res.add   = neg;
        end
        return res;
    endfunction

    // Predict on each input transaction, compare on each output transaction
    always @(posedge clk or negedge rst_n) begin
        magic_result_t want;
        int            errs;
        errs = 0;
        if (!rst_n) begin
            expected_magic_q.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                expected_magic_q.push_back(compute_magic(s_tdata[DIV_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (expected_magic_q.size() == 0) begin
                    $error("unexpected result transaction: m_tdata %h", m_tdata);
                    errs++;
                end
                else begin
                    want = expected_magic_q.pop_front();
                    if (m_tdata[33:0] !== want.magic) begin
                        $error("magic_multiplier: expected %h, actual %h",
                               want.magic, m_tdata[33:0]);
                        errs++;
                    end
                    if (m_tdata[38:34] !== want.shift) begin
                        $error("post_shift: expected %0d, actual %0d",
                               want.shift, m_tdata[38:34]);
                        errs++;
                    end
                    if (m_tdata[39] !== want.add) begin
                        $error("add_dividend: expected %b, actual %b",
                               want.add, m_tdata[39]);
                        errs++;
                    end
                    if (m_tdata[40] !== want.err) begin
                        $error("divide_error: expected %b, actual %b",
                               want.err, m_tdata[40]);
                        errs++;
                    end
                end
            end
            fail_count    <= fail_count + errs;
            pending_count <= expected_magic_q.size();
        end
    end

endmodule

/* test/signed_div_magic_constant_gen_tb.sv */
module signed_div_magic_constant_gen_tb;
    import sdmg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_START   = 30000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int STEADY_FROM  = 80000;
    localparam int STEADY_TO    = 160000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] divisor
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [33:0] magic_multiplier, [38:34] post_shift,
                                     // [39] add_dividend, [40] divide_error
    int                   fail_count;
    int                   pending_count;
    int                   cycle_count;
    bit                   steady_send;

    signed_div_magic_constant_gen dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    magic_result_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Offer one divisor and hold it until the input transaction completes
    task automatic offer_divisor(input logic [DIV_W-1:0] d);
        if (!steady_send && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Pick a divisor from a mix of ranges that stress the doubling loop
    function automatic logic [DIV_W-1:0] pick_divisor();
        logic [DIV_W-1:0] d;
        logic [DIV_W-1:0] raw;
        int               kind;
        raw  = $urandom;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: d = raw;
            4, 5:
            begin
                d = DIV_W'($urandom_range(1, 1000));
                if (raw[0])
                    d = ~d + 32'd1;
            end
            6:
            begin
                d = 32'd1 << $urandom_range(0, 31);
                d = d + DIV_W'($urandom_range(0, 2)) - 32'd1;
                if (raw[0])
                    d = ~d + 32'd1;
            end
            7:
            begin
                case ($urandom_range(0, 4))
                    0: d = 32'h0000_0000;
                    1: d = 32'h0000_0001;
                    2: d = 32'hFFFF_FFFF;
                    3: d = 32'h8000_0000;
                    default: d = 32'h7FFF_FFFF;
                endcase
            end
            8:
            begin
                if (raw[0])
                    d = 32'h7FFF_FFFF - DIV_W'($urandom_range(0, 255));
                else
                    d = 32'h8000_0000 + DIV_W'($urandom_range(0, 255));
            end
            default: d = raw >> $urandom_range(1, 30);
        endcase
        return d;
    endfunction

    // Output side: random back-pressure, one long hold-off, one steady stretch
    initial
    begin
        int rx_cycles;
        m_tready  = 1'b0;
        rx_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycles++;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
                m_tready <= 1'b0;
            else if (rx_cycles >= STEADY_FROM && rx_cycles < STEADY_TO)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 15);
        end
    end

    // Reset, directed divisors, random divisors, drain and verdict
    initial
    begin
        logic [DIV_W-1:0] directed_divisors[] = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
            32'hFFFF_FFFE, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0005,
            32'hFFFF_FFFB, 32'h0000_0007, 32'h0000_0006, 32'h0000_0281,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h4000_0000,
            32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_000A,
            32'hFFFF_FFF9, 32'h0000_0019, 32'h0001_0000
        };
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        steady_send = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_divisors[i])
            offer_divisor(directed_divisors[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady_send = (n >= 600 && n < 900);
            offer_divisor(pick_divisor());
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
